[rtl/aoc_pkg.sv]
`default_nettype none

package aoc_pkg;

    // Item kinds carried in the low bits of the input tuser.
    localparam logic [1:0] OP_COMPOSITE = 2'd0;
    localparam logic [1:0] OP_READ      = 2'd1;
    localparam logic [1:0] OP_WRITE     = 2'd2;
    localparam logic [1:0] OP_NOP       = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam int unsigned CFG_DATA_W  = 10;
    localparam logic [9:0]  CFG_DIM_RST = 10'd512;

    localparam logic [7:0]  ALPHA_MAX  = 8'hff;
    localparam logic [15:0] ROUND_HALF = 16'd127;

    typedef struct packed {
        logic [7:0] dst;
        logic [7:0] cov;
        logic [7:0] transp;
    } blend_req_t;

    // Exact floor(x / 255) for every value the blend can produce (x < 65280).
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        begin
            sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
            return sum[15:8];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/aoc_plane_ram.sv]
`default_nettype none

module aoc_plane_ram
#(
    parameter int unsigned DEPTH = 786432,
    parameter int unsigned AW    = 20
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic          re,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

[rtl/aoc_blend.sv]
`default_nettype none

module aoc_blend
    import aoc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire blend_req_t in_req,
    output logic            out_valid,
    output logic [7:0]      out_value
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [15:0] p1_reg, p1_next;
    logic [7:0]  dst1_reg, dst2_reg;
    logic [7:0]  src2_reg, src2_next, src3_reg;
    logic [15:0] p3_reg, p3_next;
    logic [7:0]  res4_reg, res4_next;
    logic [7:0]  res_sum;

    // Source alpha, then the over rule against the stored pixel.
    assign p1_next   = 16'(in_req.cov) * 16'(ALPHA_MAX - in_req.transp) + ROUND_HALF;
    assign src2_next = div255(p1_reg);
    assign p3_next   = 16'(dst2_reg) * 16'(ALPHA_MAX - src2_reg) + ROUND_HALF;
    // The over rule never exceeds full alpha, so the sum fits in eight bits.
    assign res_sum   = src3_reg + div255(p3_reg);
    assign res4_next = res_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        dst1_reg <= in_req.dst;
        src2_reg <= src2_next;
        dst2_reg <= dst1_reg;
        p3_reg   <= p3_next;
        src3_reg <= src2_reg;
        res4_reg <= res4_next;
    end

    assign out_valid = v4_reg;
    assign out_value = res4_reg;

endmodule

`default_nettype wire

[rtl/alpha_over_compositor.sv]
// A clipped or no-op item goes straight to its result. Writes and reads form an address
// and access the memory; a composite forms its address, reads, runs the 4-stage blend and
// writes back. One item is in flight at a time, as the read-modify-write of the single
// plane memory needs; the input reopens as the result enters the output register. rst_n
// is asynchronous and active low; after it a clearing pass zeroes every pixel, all
// PLANE_COUNT*MAX_WIDTH*MAX_HEIGHT (786432 by default) of them, and no item is taken.
`default_nettype none

module alpha_over_compositor
    import aoc_pkg::*;
#(
    parameter int unsigned MAX_WIDTH   = 512,
    parameter int unsigned MAX_HEIGHT  = 512,
    parameter int unsigned PLANE_COUNT = 3
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration: index 0 frame width, index 1 frame height.
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [9:0]  cfg_wdata,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // pos_x[15:0], pos_y[31:16], coverage[39:32], transparency[47:40], write_value[55:48]
    input  wire logic [55:0] s_axis_tdata,
    // opcode[1:0], plane[3:2]
    input  wire logic [3:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_value[7:0]
    output logic [7:0]       m_axis_tdata,
    // clipped[0]
    output logic             m_axis_tuser
);

    // Storage geometry. Each plane is a full MAX_WIDTH by MAX_HEIGHT block and a
    // pixel lies at plane*PLANE_SIZE + y*width + x, width being the live row pitch.
    localparam int unsigned PLANE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned DEPTH      = PLANE_COUNT * PLANE_SIZE;
    localparam int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned WW         = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW         = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned PW         = YW + WW;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_ADDR  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_BLEND = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [9:0]    cfg_w_reg, cfg_h_reg;

    logic [1:0]    op_reg;
    logic [1:0]    plane_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [7:0]    cov_reg, transp_reg, wval_reg;
    logic [PW-1:0] prod_reg;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] addr_reg;
    logic [7:0]    res_reg, res_next;
    logic          clip_reg, clip_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg;
    logic          out_clip_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic          in_accept;
    logic          in_clip;
    logic [15:0]   in_x, in_y;
    logic [1:0]    in_op, in_plane;
    logic          out_free;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic          blend_start;
    blend_req_t    blend_req;
    logic          blend_done;
    logic [7:0]    blend_value;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= CFG_DIM_RST;
            cfg_h_reg <= CFG_DIM_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WIDTH:  cfg_w_reg <= cfg_wdata;
                CFG_HEIGHT: cfg_h_reg <= cfg_wdata;
                default:    cfg_w_reg <= cfg_w_reg;
            endcase
        end
    end

    // Frame size as used: the register value saturated to the storage size.
    assign w_eff = (32'(cfg_w_reg) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)
                                                      : WW'(cfg_w_reg);
    assign h_eff = (32'(cfg_h_reg) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                      : HW'(cfg_h_reg);

    // ------------------------------------------------------------------
    // Input decode and clipping.
    // ------------------------------------------------------------------
    assign in_op    = s_axis_tuser[1:0];
    assign in_plane = s_axis_tuser[3:2];
    assign in_x     = s_axis_tdata[15:0];
    assign in_y     = s_axis_tdata[31:16];

    // A negative coordinate, one at or beyond the frame edge, or a plane that
    // does not exist means the item touches no storage.
    assign in_clip = (32'(in_plane) >= 32'(PLANE_COUNT)) ||
                     in_x[15] || in_y[15] ||
                     (32'(in_x) >= 32'(w_eff)) ||
                     (32'(in_y) >= 32'(h_eff));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // The output register is free when empty or when its item leaves this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer. One item is worked at a time, which also serves as the
    // interlock between the read and the write-back of the same pixel.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        res_next     = res_reg;
        clip_next    = clip_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = addr_reg;
        ram_wdata    = wval_reg;
        blend_start  = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = 8'd0;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_next = 8'd0;
                    if (in_op == OP_NOP)
                    begin
                        clip_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else if (in_clip)
                    begin
                        clip_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        clip_next  = 1'b0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (op_reg == OP_WRITE)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = wval_reg;
                    res_next   = wval_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (op_reg == OP_READ)
                begin
                    res_next   = ram_rdata;
                    state_next = ST_DONE;
                end
                else
                begin
                    blend_start = 1'b1;
                    state_next  = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (blend_done)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = blend_value;
                    res_next   = blend_value;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Item fields, address arithmetic and the pending result.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg     <= in_op;
            plane_reg  <= in_plane;
            x_reg      <= in_x[XW-1:0];
            y_reg      <= in_y[YW-1:0];
            cov_reg    <= s_axis_tdata[39:32];
            transp_reg <= s_axis_tdata[47:40];
            wval_reg   <= s_axis_tdata[55:48];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PW'(y_reg) * PW'(w_eff);
            base_reg <= AW'(plane_reg) * AW'(PLANE_SIZE);
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= base_reg + AW'(prod_reg) + AW'(x_reg);
        end
        res_reg  <= res_next;
        clip_reg <= clip_next;
    end

    // ------------------------------------------------------------------
    // Output register: holds a finished result until it is taken.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= res_reg;
            out_clip_reg <= clip_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_clip_reg;

    // ------------------------------------------------------------------
    // Plane memory and blend pipeline.
    // ------------------------------------------------------------------
    aoc_plane_ram
    #(
        .DEPTH (DEPTH),
        .AW    (AW)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign blend_req.dst    = ram_rdata;
    assign blend_req.cov    = cov_reg;
    assign blend_req.transp = transp_reg;

    aoc_blend u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (blend_start),
        .in_req    (blend_req),
        .out_valid (blend_done),
        .out_value (blend_value)
    );

endmodule

`default_nettype wire

[rtl/aoc_checker.sv]
`default_nettype none

module aoc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // A clipped item accesses nothing and reports a zero pixel.
    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 8'd0))
        else $error("clipped result with non-zero pixel");

    // Items are worked one at a time: an accepted item closes the input.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input reopened straight after an accepted item");

    // No result can appear in the cycle right after an item is accepted.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind alpha_over_compositor aoc_checker u_aoc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
